### rtl/core/fir_lowpass_511_tap_defines.svh
// Assertion macros shared by the low-pass FIR RTL
`ifndef FIR_LOWPASS_511_TAP_DEFINES_SVH
`define FIR_LOWPASS_511_TAP_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define FLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fir lowpass: same-cycle check failed");

// Antecedent implies consequent in the next cycle
`define FLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fir lowpass: next-cycle check failed");

`endif

### rtl/core/flp511_pkg.sv
// Package for the low-pass FIR: defaults, sequencer states and coefficient table
`default_nettype none
package flp511_pkg;

  localparam int TAPS_DEF           = 511;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;

  localparam int DESIGN_TAPS   = 511;
  localparam int DESIGN_CENTER = 255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } flp_state_e;

  // Design coefficients as two groups of nine decimal digits; a negative upper group
  // marks a negative coefficient.
  localparam int COEF_HI [DESIGN_CENTER+1] = '{
    868, 29299, -2605, -29398, 4342, 29562, -6081, -29791,
    7822, 30086, -9565, -30445, 11311, 30869, -13060, -31358,
    14813, 31910, -16569, -32525, 18329, 33203, -20093, -33943,
    21860, 34744, -23631, -35604, 25405, 36523, -27181, -37500,
    28959, 38533, -30738, -39620, 32517, 40759, -34295, -41949,
    36069, 43187, -37838, -44470, 39600, 45796, -41352, -47162,
    43092, 48563, -44817, -49995, 46523, 51455, -48206, -52937,
    49861, 54437, -51485, -55947, 53071, 57462, -54615, -58974,
    56108, 60475, -57546, -61957, 58919, 63409, -60221, -64821,
    61441, 66182, -62571, -67479, 63601, 68698, -64519, -69825,
    65313, 70843, -65972, -71735, 66481, 72482, -66827, -73064,
    66994, 73458, -66965, -73642, 66722, 73590, -66248, -73275,
    65520, 72668, -64518, -71738, 63218, 70451, -61593, -68771,
    59617, 66659, -57259, -64073, 54488, 60968, -51269, -57294,
    47565, 52998, -43338, -48022, 38544, 42304, -33141, -35775,
    27082, 28362, -20319, -19986, 12802, 10562, -4479, 0,
    -4701, -11796, 14795, 24928, -25859, -39501, 37949, 55625,
    -51126, -73411, 65455, 92974, -81004, -114432, 97851, 137900,
    -116083, -163499, 135803, 191350, -157131, -221581, 180211, 254327,
    -205211, -289736, 232330, 327974, -261803, -369232, 293903, 413737,
    -328942, -461762, 367281, 513648, -409317, -569818, 455479, 630808,
    -506203, -697282, 561896, 770041, -622896, -850011, 689423, 938215,
    -761557, -1035732, 839227, 1143656, -922229, -1263092, 1010228, 1395176,
    -1102748, -1541115, 1199083, 1702233, -1298082, -1879900, 1397836, 2075172,
    -1495441, -2288099, 1587162, 2516959, -1669118, -2757766, 1738305, 3004194,
    -1793743, -3247763, 1838274, 3479470, -1880052, -3693726, 1930698, 3891863,
    -1999277, -4080891, 2084847, 4262499, -2181043, -4427524, 2284899, 4561049,
    -2391631, -4630548, 2504121, 4574995, -2653150, -4279727, 3007532, 3713479,
    -3853498, -3116188, 5278058, 2747298, -7244902, -2881277, 9457054, 3351135,
    -12167166, -4543412, 15527921, 8085750, -16517158, -11259700, 15563606, 12454246,
    -12929466, -7007643, 16994448, -548894, -36312476, -15670182, 30326812, 7170776,
    -46473179, -9796747, 65461256, 9810014, -111123282, -10013410, 336368420, 539047706
  };

  localparam int COEF_LO [DESIGN_CENTER+1] = '{
    241067156, 641007260, 13504707, 104318961, 627038582, 99725110, 595872537, 508765674,
    435900675, 145858119, 641749318, 730368661, 627105555, 929950409, 735236841, 371936158,
    275336879, 582667282, 478672325, 972886262, 442598107, 888820783, 163014060, 596930443,
    559554603, 210023194, 405587409, 696663394, 287759918, 931315700, 660242050, 641060092,
    841193410, 331950133, 919906417, 329632594, 748430178, 807688845, 4401157, 692284334,
    140621643, 610600073, 287394672, 955245448, 287239902, 863420674, 739212195, 91384308,
    896143136, 4675716, 592584686, 639028417, 317220884, 610394655, 207480587, 988140644,
    912760686, 331154791, 578211492, 705292477, 928965835, 527574654, 196525294, 475292840,
    988423252, 548917461, 340361477, 12852565, 771094626, 208102617, 147128260, 526290217,
    603514998, 461485785, 642223874, 468107767, 114413177, 797354992, 52371853, 537504345,
    660473227, 610397215, 399125305, 572446911, 863949914, 518901068, 618059245, 147557413,
    224093518, 658826184, 234288976, 534096665, 965485356, 495846514, 353942044, 502303518,
    966445791, 514829274, 853085200, 258632479, 272668449, 152322451, 594561407, 125652782,
    257267325, 240823848, 543642588, 409355520, 383027343, 186458387, 355733846, 379136930,
    665941709, 586406516, 23444783, 893267399, 687146743, 564954619, 646290362, 642761606,
    729598884, 660807138, 731621847, 534371360, 665273263, 473232725, 972634933, 180,
    375421665, 807869501, 811375856, 948636561, 260342849, 990815215, 526302465, 335103901,
    944492553, 408881308, 476916747, 932275311, 514688615, 199499848, 255867997, 696152138,
    570813860, 578063455, 616027661, 950873335, 947035957, 861366268, 435170985, 566473539,
    124935398, 175841487, 505926261, 33941446, 679024529, 422609613, 20905332, 322358600,
    788451413, 810373607, 276609950, 7178211, 569809855, 190870654, 809906561, 332309494,
    349093627, 466373291, 579547685, 106668098, 193318166, 150725756, 489276809, 898016316,
    43722611, 391888875, 801072064, 374289662, 383310394, 852606703, 564604413, 399623642,
    940536298, 625821356, 18064057, 637864624, 688555196, 703339095, 798771884, 527480989,
    8551891, 243494170, 268609710, 448474575, 718787738, 685739880, 226438895, 96214564,
    35168472, 44738111, 446210765, 703967718, 384761281, 467835952, 456826084, 505979095,
    906431073, 709136158, 790273016, 509943752, 676321256, 60232353, 272606889, 505174422,
    527576649, 284319288, 110486238, 613363008, 999259743, 512878172, 55911877, 468103077,
    318804421, 508079166, 207921479, 95588335, 174942130, 523830999, 302174803, 767186465,
    132004519, 820913118, 735547233, 334508069, 339044408, 424133302, 604588555, 37188567,
    557060509, 762822077, 685648589, 445659560, 492396828, 461999020, 985826110, 403021785,
    418518945, 959099448, 370524551, 540351210, 243399960, 2132218, 39784840, 807930900
  };

  // Quantised coefficient of tap idx, rounded half away from zero; zero beyond the table
  function automatic longint coef_val(input int idx, input int frac);
    longint unsigned one;
    longint unsigned a;
    longint unsigned b;
    longint unsigned m;
    longint unsigned q;
    int              j;
    int              hi;
    if (idx >= DESIGN_TAPS) begin
      return 64'sd0;
    end
    j   = (idx <= DESIGN_CENTER) ? idx : (DESIGN_TAPS - 1 - idx);
    hi  = COEF_HI[j];
    a   = (hi < 0) ? 64'(-hi) : 64'(hi);
    b   = 64'(COEF_LO[j]);
    one = 64'd1 << frac;
    m   = a * one;
    q   = (m / 64'd1000000000) +
          (((m % 64'd1000000000) * 64'd1000000000 + b * one + 64'd500000000000000000)
           / 64'd1000000000000000000);
    return (hi < 0) ? -longint'(q) : longint'(q);
  endfunction

endpackage
`default_nettype wire

### rtl/core/fir_lowpass_511_tap.sv
// Low-pass FIR filter, 511 taps, one shared multiply-accumulate over a circular delay line.
// Each sample goes through these steps from its transfer to its result: one
// multiply-accumulate per tap, walked by a tap counter through the delay-line RAM and the
// coefficient ROM, then a drain of the read and product pipeline registers, then a
// saturation into the output register. The input is not ready while a sample is in work
// and comes back ready the cycle after the result is loaded, so a new sample is taken only
// once the last is through. The result waits in an output register so the next sample can
// be taken while it is unread; if that earlier result is still unread when the next one is
// ready, the sequencer holds until it is taken. Delay-line entries not yet written since
// reset count as zero through a fill counter, so no clearing pass is needed after reset.
`default_nettype none
`include "fir_lowpass_511_tap_defines.svh"
module fir_lowpass_511_tap #(
  parameter int TAPS           = flp511_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS    = flp511_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = flp511_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata   // filtered
);
  import flp511_pkg::*;

  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW = $clog2(TAPS + 1);
  localparam int CW = COEF_FRAC_BITS + 1;
  localparam int PW = SAMPLE_BITS + CW;
  localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);
  localparam logic [63:0]   MAXPOS   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  logic signed [CW-1:0] coef_rom [TAPS];
  for (genvar g = 0; g < TAPS; g++) begin : g_rom
    assign coef_rom[g] = CW'(coef_val(g, COEF_FRAC_BITS));
  end

  logic [SAMPLE_BITS-1:0] mem [TAPS];

  flp_state_e state_q, state_d;
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d, tap_q, tap_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          v1_q, v1_d, v2_q, v2_d, live1_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic signed [CW-1:0]          coef_q;
  logic signed [PW-1:0]          prod_q;
  logic [63:0]                   acc_q;
  logic                          ovld_q, ovld_d;
  logic [SAMPLE_BITS-1:0]        out_q;
  logic [SAMPLE_BITS-1:0]        res;
  logic [63:0]                   mag, qv;
  logic                          accept, load_out, neg;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = DW'(out_q);

  always_comb begin
    neg = acc_q[63];
    mag = neg ? (64'd0 - acc_q) : acc_q;
    qv  = mag >> COEF_FRAC_BITS;
    if (!neg) begin
      res = (qv > MAXPOS) ? SAMPLE_BITS'(MAXPOS) : SAMPLE_BITS'(qv);
    end else begin
      res = (qv > MAXPOS + 64'd1) ? SAMPLE_BITS'(64'd0 - (MAXPOS + 64'd1))
                                  : SAMPLE_BITS'(64'd0 - qv);
    end
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    tap_d    = tap_q;
    fill_d   = fill_q;
    v1_d     = 1'b0;
    v2_d     = v1_q;
    load_out = 1'b0;
    ovld_d   = ovld_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rp_d    = wp_q;
          wp_d    = (wp_q == LAST_IDX) ? '0 : wp_q + AW'(1);
          tap_d   = '0;
          fill_d  = (fill_q == FW'(TAPS)) ? fill_q : fill_q + FW'(1);
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        v1_d  = 1'b1;
        rp_d  = (rp_q == '0) ? LAST_IDX : rp_q - AW'(1);
        tap_d = (tap_q == LAST_IDX) ? tap_q : tap_q + AW'(1);
        if (tap_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ovld_q || m_axis_tready) begin
          load_out = 1'b1;
          ovld_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      tap_q   <= '0;
      fill_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      tap_q   <= tap_d;
      fill_q  <= fill_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wp_q] <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    rd_data_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    coef_q  <= coef_rom[tap_q];
    live1_q <= (FW'(tap_q) < fill_q);
    prod_q  <= live1_q ? PW'(rd_data_q * coef_q) : '0;
    if (accept) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + 64'(prod_q);
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  `FLP_ASSERT_NOW(a_idle_pipe_empty, state_q == ST_IDLE, !v1_q && !v2_q)
  `FLP_ASSERT_NEXT(a_accept_starts_mac, accept, state_q == ST_MAC && tap_q == '0)
  `FLP_ASSERT_NOW(a_fill_bounded, 1'b1, fill_q <= FW'(TAPS))
  `FLP_ASSERT_NOW(a_fin_pipe_empty, state_q == ST_FIN, !v1_q && !v2_q)

endmodule
`default_nettype wire

### test/tb_fir_lowpass_511_tap.sv
// Testbench for the 511-tap low-pass FIR: directed table, random streams, checked per transfer
`default_nettype none
module tb_fir_lowpass_511_tap;
  import flp511_pkg::*;

  localparam int NTAPS     = 511;
  localparam int SW        = 24;
  localparam int FRAC      = 24;
  localparam int DW        = ((SW + 7) / 8) * 8;
  localparam int RAND_ITEMS = 380;
  localparam int HOLD_CYC  = 3000;
  localparam int IDLE_LIMIT = 12000;
  localparam int TAIL_CYC  = 600;
  localparam logic [SW-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SW-1:0] S_MIN = 24'h800000;

  typedef struct {
    logic [SW-1:0] sample;
    bit            known;
    logic [SW-1:0] filtered;
  } stim_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_tvalid = 1'b0;
  logic [DW-1:0] s_tdata = '0;
  logic          m_tready = 1'b0;
  logic          s_axis_tready;
  logic          m_axis_tvalid;
  logic [DW-1:0] m_axis_tdata;

  longint        coefs [NTAPS];
  longint        dline [NTAPS];
  logic [SW-1:0] expected_filtered [$];
  stim_row_t     stim [$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            idle_cycles = 0;

  fir_lowpass_511_tap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),       // [23:0] sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)   // [23:0] filtered
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint quantise(int hi, int lo);
    logic [127:0] mag;
    logic [127:0] q;
    longint       r;
    mag = (128'(hi < 0 ? -hi : hi) * 128'd1000000000 + 128'(lo)) << FRAC;
    q   = (mag + 128'd500000000000000000) / 128'd1000000000000000000;
    r   = longint'(q[63:0]);
    return (hi < 0) ? -r : r;
  endfunction

  // shift in the sample and form the truncated, saturated tap sum
  function automatic logic [SW-1:0] filter_next(logic [SW-1:0] x);
    longint        acc;
    logic   [63:0] m;
    logic   [63:0] q;
    logic          neg;
    for (int i = NTAPS - 1; i > 0; i--) dline[i] = dline[i-1];
    dline[0] = longint'(signed'(x));
    acc = 0;
    for (int i = 0; i < NTAPS; i++) acc += dline[i] * coefs[i];
    neg = acc < 0;
    m   = neg ? 64'(-acc) : 64'(acc);
    q   = m >> FRAC;
    if (!neg) begin
      if (q > 64'(S_MAX)) q = 64'(S_MAX);
      return q[SW-1:0];
    end
    if (q > 64'(S_MAX) + 1) q = 64'(S_MAX) + 1;
    q = -q;
    return q[SW-1:0];
  endfunction

  function automatic void add_row(logic [SW-1:0] x, bit known = 0, logic [SW-1:0] y = '0);
    stim_row_t r;
    r.sample = x;
    r.known = known;
    r.filtered = y;
    stim.push_back(r);
  endfunction

  function automatic logic [SW-1:0] near_full(bit pos);
    logic [SW-1:0] a;
    a = S_MAX - 24'($urandom_range(0, 255));
    return pos ? a : ~a;
  endfunction

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[fir_lowpass_511_tap] ERROR");
      $finish;
    end
  end

  // receiver: random stall pattern in epochs, one long hold-off
  initial begin
    int  hold_cnt;
    bit  hold_done;
    int  cyc;
    logic [SW-1:0] want;
    hold_cnt = 0;
    hold_done = 0;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (rst_ni) begin
        if (m_axis_tvalid && m_tready) begin
          results_seen++;
          if (expected_filtered.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata[SW-1:0]);
          end else begin
            want = expected_filtered.pop_front();
            if (m_axis_tdata[SW-1:0] !== want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("filtered mismatch: expected %h got %h", want, m_axis_tdata[SW-1:0]);
            end
          end
        end
        if (!hold_done && results_seen >= 60) begin
          hold_cnt = HOLD_CYC;
          hold_done = 1;
        end
        if (hold_cnt > 0) begin
          hold_cnt--;
          m_tready <= 1'b0;
        end else if ((cyc / 1500) % 3 == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // sender
  initial begin
    int            burst;
    int            n;
    int            len;
    int            mode;
    bit            pol;
    logic [SW-1:0] y;
    for (int i = 0; i < NTAPS; i++) begin
      coefs[i] = quantise(COEF_HI[i <= DESIGN_CENTER ? i : NTAPS - 1 - i],
                          COEF_LO[i <= DESIGN_CENTER ? i : NTAPS - 1 - i]);
      dline[i] = 0;
    end

    add_row('0, 1, '0);
    add_row('0, 1, '0);
    add_row(S_MAX);
    add_row(S_MIN);
    add_row(24'h000001);
    add_row(24'hFFFFFF);
    add_row(24'h555555);
    add_row(24'hAAAAAA);
    for (int k = 0; k < 12; k++) add_row((k % 4) < 2 ? S_MAX : S_MIN);
    for (int k = 0; k < 5; k++) add_row((k % 4) < 2 ? S_MIN : S_MAX);

    n = 0;
    while (n < RAND_ITEMS) begin
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
        add_row(24'($urandom));
        n++;
      end else if (mode < 75) begin
        case ($urandom_range(0, 3))
          0: add_row(S_MAX);
          1: add_row(S_MIN);
          2: add_row(24'($urandom_range(0, 15)));
          default: add_row(~24'($urandom_range(0, 15)));
        endcase
        n++;
      end else begin
        len = $urandom_range(8, 16);
        pol = $urandom_range(0, 1);
        for (int k = 0; k < len; k++) add_row(near_full(((k % 4) < 2) ^ pol));
        n += len;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    burst = 0;
    for (int idx = 0; idx < stim.size(); idx++) begin
      if (idx == 200) begin
        s_tvalid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge clk_i);
      end else if (burst <= 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        burst = $urandom_range(1, 10);
      end
      burst--;
      s_tvalid <= 1'b1;
      s_tdata <= stim[idx].sample;
      do @(posedge clk_i); while (!s_axis_tready);
      y = filter_next(stim[idx].sample);
      if (stim[idx].known && y !== stim[idx].filtered) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", idx);
      end
      expected_filtered.push_back(stim[idx].known ? stim[idx].filtered : y);
    end
    s_tvalid <= 1'b0;

    while (expected_filtered.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("[fir_lowpass_511_tap] OK");
    end else begin
      $display("[fir_lowpass_511_tap] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
